@@ src/iras_pkg.sv @@
// iras_pkg: shared widths, register map, reset values and control struct
// for the interval room allocator; used by every module under src
package iras_pkg;

  localparam int TIME_W = 31;
  localparam int ID_W   = 16;
  localparam int ROOM_W = 7;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  localparam int MAX_ROOMS_DEF = 64;

  // register index is the word address, paddr[CFG_AW-1]
  localparam logic REG_ROOM_COUNT = 1'b0;

  localparam logic [ROOM_W-1:0] ROOM_COUNT_RST = 7'd1;

  // request from the sequencer to the free-time store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } mem_ctl_t;

endpackage

@@ src/iras_time_store.sv @@
// iras_time_store: free-time memory of all rooms with per-room valid bits
// depends on iras_pkg; an entry without its valid bit reads as time zero
module iras_time_store #(
  parameter int MAX_ROOMS = iras_pkg::MAX_ROOMS_DEF,
  localparam int IDX_W = $clog2(MAX_ROOMS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  iras_pkg::mem_ctl_t          mem_ctl,
  input  logic [IDX_W-1:0]            raddr,
  input  logic [IDX_W-1:0]            waddr,
  input  logic [iras_pkg::TIME_W-1:0] wdata,
  output logic [iras_pkg::TIME_W-1:0] rdata
);

  logic [iras_pkg::TIME_W-1:0] mem_r [MAX_ROOMS];
  logic [MAX_ROOMS-1:0]        valid_r;
  logic [iras_pkg::TIME_W-1:0] rd_q_r;
  logic                        rd_valid_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem_r[waddr] <= wdata;
    end
    if (mem_ctl.rd_en) begin
      rd_q_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (mem_ctl.clear_all) begin
        valid_r <= '0;
      end else if (mem_ctl.wr_en) begin
        valid_r[waddr] <= 1'b1;
      end
      if (mem_ctl.rd_en) begin
        rd_valid_r <= valid_r[raddr];
      end
    end
  end

  assign rdata = rd_valid_r ? rd_q_r : '0;

endmodule

@@ src/iras_ctrl.sv @@
// iras_ctrl: sequencer that scans the active rooms through one shared compare
// unit, keeps the earliest free room and books it if the lecture fits; uses iras_pkg
module iras_ctrl #(
  parameter int MAX_ROOMS = iras_pkg::MAX_ROOMS_DEF,
  localparam int IDX_W = $clog2(MAX_ROOMS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_new_pass,
  input  logic [iras_pkg::ID_W-1:0]   in_lecture_id,
  input  logic [iras_pkg::TIME_W-1:0] in_start_time,
  input  logic [iras_pkg::TIME_W-1:0] in_end_time,
  input  logic [iras_pkg::ROOM_W-1:0] room_count,
  output iras_pkg::mem_ctl_t          mem_ctl,
  output logic [IDX_W-1:0]            mem_raddr,
  output logic [IDX_W-1:0]            mem_waddr,
  output logic [iras_pkg::TIME_W-1:0] mem_wdata,
  input  logic [iras_pkg::TIME_W-1:0] mem_rdata,
  output logic                        out_strobe,
  output logic [iras_pkg::ID_W-1:0]   out_lecture_echo,
  output logic [iras_pkg::ROOM_W-1:0] out_room,
  output logic                        out_ok
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            last_r, last_nxt;
  logic [IDX_W-1:0]            ptr_r, ptr_nxt;
  logic                        issue_r, issue_nxt;
  logic                        pend_r, pend_nxt;
  logic [IDX_W-1:0]            pend_idx_r, pend_idx_nxt;
  logic [iras_pkg::TIME_W-1:0] best_time_r, best_time_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic                        failed_r, failed_nxt;
  logic [iras_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [iras_pkg::TIME_W-1:0] start_r, start_nxt;
  logic [iras_pkg::TIME_W-1:0] end_r, end_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  logic                        out_ok_r, out_ok_nxt;
  logic [iras_pkg::ROOM_W-1:0] out_room_r, out_room_nxt;
  logic [iras_pkg::ID_W-1:0]   out_id_r, out_id_nxt;

  logic        accept;
  logic        hit;
  logic [31:0] cnt_full;

  assign accept = start && (state_r == ST_IDLE);
  assign hit    = (start_r >= best_time_r);

  always_comb begin
    cnt_full = (room_count == '0) ? 32'd1 : {25'd0, room_count};
    if (cnt_full > 32'(MAX_ROOMS)) begin
      cnt_full = 32'(MAX_ROOMS);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    ptr_nxt        = ptr_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    best_time_nxt  = best_time_r;
    best_idx_nxt   = best_idx_r;
    failed_nxt     = failed_r;
    id_nxt         = id_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    out_strobe_nxt = 1'b0;
    out_ok_nxt     = out_ok_r;
    out_room_nxt   = out_room_r;
    out_id_nxt     = out_id_r;
    mem_ctl        = '0;
    mem_raddr      = ptr_r;
    mem_waddr      = best_idx_r;
    mem_wdata      = end_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          id_nxt            = in_lecture_id;
          start_nxt         = in_start_time;
          end_nxt           = in_end_time;
          mem_ctl.clear_all = in_new_pass;
          if (in_new_pass) begin
            failed_nxt = 1'b0;
          end
          if (failed_r && !in_new_pass) begin
            // failed pass: answer at once, no room touched
            out_strobe_nxt = 1'b1;
            out_ok_nxt     = 1'b0;
            out_room_nxt   = '0;
            out_id_nxt     = in_lecture_id;
          end else begin
            state_nxt = ST_SCAN;
            last_nxt  = IDX_W'(cnt_full - 32'd1);
            ptr_nxt   = '0;
            issue_nxt = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        mem_ctl.rd_en = issue_r;
        pend_nxt      = issue_r;
        pend_idx_nxt  = ptr_r;
        if (issue_r) begin
          if (ptr_r == last_r) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
        // strict less keeps the lowest room on equal free times
        if (pend_r) begin
          if ((pend_idx_r == '0) || (mem_rdata < best_time_r)) begin
            best_time_nxt = mem_rdata;
            best_idx_nxt  = pend_idx_r;
          end
          if (pend_idx_r == last_r) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        mem_ctl.wr_en  = hit;
        failed_nxt     = !hit;
        out_strobe_nxt = 1'b1;
        out_ok_nxt     = hit;
        out_room_nxt   = hit ? iras_pkg::ROOM_W'({1'b0, best_idx_r} + 1'b1) : '0;
        out_id_nxt     = id_r;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_r      <= 1'b0;
      pend_r       <= 1'b0;
      failed_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      pend_r       <= pend_nxt;
      failed_r     <= failed_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    ptr_r       <= ptr_nxt;
    pend_idx_r  <= pend_idx_nxt;
    best_time_r <= best_time_nxt;
    best_idx_r  <= best_idx_nxt;
    id_r        <= id_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    out_ok_r    <= out_ok_nxt;
    out_room_r  <= out_room_nxt;
    out_id_r    <= out_id_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_ok           = out_ok_r;
  assign out_room         = out_room_r;
  assign out_lecture_echo = out_id_r;

`ifndef SYNTHESIS
  a_wr_gives_ok: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |=> (out_strobe && out_ok))
    else $error("room write without an ok result");

  a_failed_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && failed_r && !in_new_pass) |=> (out_strobe && !out_ok && (out_room == '0)))
    else $error("failed pass did not answer at once");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (state_r == ST_IDLE))
    else $error("result beat while still scanning");

  a_ok_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_ok) |-> (out_room != '0))
    else $error("ok result without a room");
`endif

endmodule

@@ src/interval_room_allocator_top.sv @@
// interval_room_allocator_top: register port, sequencer and free-time store
// depends on iras_pkg, iras_time_store and iras_ctrl
//
//   channel  ports                                   handshake
//   input    in_new_pass in_lecture_id in_start_time start & !busy
//            in_end_time
//   result   out_lecture_echo out_room out_ok        out_strobe, one cycle
//   config   psel penable pwrite paddr pwdata prdata write in access phase
//
// an item keeps busy high for one memory read per active room through a single
// compare, the registered read data and a booking state that books the room
// only if free; the result beat follows in the next cycle. a failed pass
// answers an item without a scan. reset is synchronous and frees all rooms
// at once via the valid bits; results cannot be stalled, the strobe lasts exactly one cycle.
module interval_room_allocator_top #(
  parameter int MAX_ROOMS = iras_pkg::MAX_ROOMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_new_pass,
  input  logic [iras_pkg::ID_W-1:0]   in_lecture_id,
  input  logic [iras_pkg::TIME_W-1:0] in_start_time,
  input  logic [iras_pkg::TIME_W-1:0] in_end_time,
  output logic                        out_strobe,
  output logic [iras_pkg::ID_W-1:0]   out_lecture_echo,
  output logic [iras_pkg::ROOM_W-1:0] out_room,
  output logic                        out_ok,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iras_pkg::CFG_AW-1:0] paddr,
  input  logic [iras_pkg::CFG_DW-1:0] pwdata,
  output logic [iras_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int IDX_W = $clog2(MAX_ROOMS);

  logic [iras_pkg::ROOM_W-1:0] room_count_r;
  logic                        cfg_wr;
  iras_pkg::mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]            mem_raddr;
  logic [IDX_W-1:0]            mem_waddr;
  logic [iras_pkg::TIME_W-1:0] mem_wdata;
  logic [iras_pkg::TIME_W-1:0] mem_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[iras_pkg::CFG_AW-1] == iras_pkg::REG_ROOM_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_count_r <= iras_pkg::ROOM_COUNT_RST;
    end else if (cfg_wr) begin
      room_count_r <= pwdata[iras_pkg::ROOM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[iras_pkg::CFG_AW-1] == iras_pkg::REG_ROOM_COUNT) begin
      prdata = {{(iras_pkg::CFG_DW - iras_pkg::ROOM_W){1'b0}}, room_count_r};
    end
  end

  iras_ctrl #(
    .MAX_ROOMS(MAX_ROOMS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_new_pass      (in_new_pass),
    .in_lecture_id    (in_lecture_id),
    .in_start_time    (in_start_time),
    .in_end_time      (in_end_time),
    .room_count       (room_count_r),
    .mem_ctl          (mem_ctl),
    .mem_raddr        (mem_raddr),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_rdata        (mem_rdata),
    .out_strobe       (out_strobe),
    .out_lecture_echo (out_lecture_echo),
    .out_room         (out_room),
    .out_ok           (out_ok)
  );

  iras_time_store #(
    .MAX_ROOMS(MAX_ROOMS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_ctl (mem_ctl),
    .raddr   (mem_raddr),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .rdata   (mem_rdata)
  );

endmodule

@@ tb/sv/testbench.sv @@
// testbench for interval_room_allocator_top: directed table, then random passes of mostly
// sorted intervals, every result beat checked against a typed-in expectation or an earliest-free-room predictor
// depends on iras_pkg and the allocator rtl under src
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_ROOMS = iras_pkg::MAX_ROOMS_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [iras_pkg::CFG_AW-1:0] ROOM_COUNT_ADDR = {iras_pkg::REG_ROOM_COUNT, 2'b00};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [iras_pkg::ROOM_W-1:0] cfg_val;
    logic                        new_pass;
    logic [iras_pkg::ID_W-1:0]   id;
    logic [iras_pkg::TIME_W-1:0] start_t;
    logic [iras_pkg::TIME_W-1:0] end_t;
    logic                        fixed;
    logic [iras_pkg::ROOM_W-1:0] room;
    logic                        ok;
  } row_t;

  typedef struct {
    logic [iras_pkg::ID_W-1:0]   id;
    logic [iras_pkg::ROOM_W-1:0] room;
    logic                        ok;
  } booking_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        in_new_pass = 1'b0;
  logic [iras_pkg::ID_W-1:0]   in_lecture_id = '0;
  logic [iras_pkg::TIME_W-1:0] in_start_time = '0;
  logic [iras_pkg::TIME_W-1:0] in_end_time = '0;
  logic                        out_strobe;
  logic [iras_pkg::ID_W-1:0]   out_lecture_echo;
  logic [iras_pkg::ROOM_W-1:0] out_room;
  logic                        out_ok;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [iras_pkg::CFG_AW-1:0] paddr = '0;
  logic [iras_pkg::CFG_DW-1:0] pwdata = '0;
  logic [iras_pkg::CFG_DW-1:0] prdata;
  logic                        pready;

  // typed-in expectation travels with the beat it belongs to
  logic                        fixed_exp = 1'b0;
  logic [iras_pkg::ROOM_W-1:0] fixed_room = '0;
  logic                        fixed_ok = 1'b0;

  // predictor state
  logic [iras_pkg::TIME_W-1:0] free_time [MAX_ROOMS];
  logic                        pass_dead = 1'b0;
  logic [iras_pkg::ROOM_W-1:0] room_count_reg = iras_pkg::ROOM_COUNT_RST;

  booking_t bookings_q [$];
  int       mismatches = 0;
  int       cycles = 0;
  int       burst_left = 0;

  row_t plan [24] = '{
    // after reset, one room
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0000, 31'd0, 31'd0, 1'b1, 7'd1, 1'b1},
    '{ROW_ITEM, 7'd0, 1'b0, 16'hFFFF, 31'd5, 31'h7FFFFFFF, 1'b1, 7'd1, 1'b1},
    // no room free, then sticky failure
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0001, 31'd10, 31'd20, 1'b1, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0002, 31'h7FFFFFFF, 31'd0, 1'b1, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b1, 16'h0003, 31'd0, 31'd100, 1'b1, 7'd1, 1'b1},
    // end before start
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0004, 31'd100, 31'd50, 1'b1, 7'd1, 1'b1},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0005, 31'd50, 31'd60, 1'b1, 7'd1, 1'b1},
    // zero rooms is taken as one
    '{ROW_CFG, 7'd0, 1'b0, 16'h0, 31'd0, 31'd0, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b1, 16'h0006, 31'd0, 31'd10, 1'b1, 7'd1, 1'b1},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0007, 31'd5, 31'd6, 1'b1, 7'd0, 1'b0},
    // tie on free time goes to the lowest room
    '{ROW_CFG, 7'd2, 1'b0, 16'h0, 31'd0, 31'd0, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b1, 16'h0010, 31'd0, 31'd10, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0011, 31'd0, 31'd20, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0012, 31'd10, 31'd30, 1'b0, 7'd0, 1'b0},
    // room count grows mid-pass, new room still free at zero
    '{ROW_CFG, 7'd3, 1'b0, 16'h0, 31'd0, 31'd0, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0013, 31'd15, 31'd40, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0014, 31'd16, 31'd17, 1'b0, 7'd0, 1'b0},
    '{ROW_CFG, 7'd64, 1'b0, 16'h0, 31'd0, 31'd0, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b1, 16'hAAAA, 31'd0, 31'h7FFFFFFF, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h5555, 31'd1, 31'd2, 1'b0, 7'd0, 1'b0},
    // above the room maximum is clamped
    '{ROW_CFG, 7'd127, 1'b0, 16'h0, 31'd0, 31'd0, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b1, 16'h0020, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, 7'd0, 1'b0},
    '{ROW_CFG, 7'd65, 1'b0, 16'h0, 31'd0, 31'd0, 1'b0, 7'd0, 1'b0},
    '{ROW_ITEM, 7'd0, 1'b0, 16'h0021, 31'h7FFFFFFF, 31'd0, 1'b0, 7'd0, 1'b0}
  };

  interval_room_allocator_top #(.MAX_ROOMS(MAX_ROOMS)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_new_pass      (in_new_pass),
    .in_lecture_id    (in_lecture_id),
    .in_start_time    (in_start_time),
    .in_end_time      (in_end_time),
    .out_strobe       (out_strobe),
    .out_lecture_echo (out_lecture_echo),
    .out_room         (out_room),
    .out_ok           (out_ok),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk = ~clk;

  initial begin
    foreach (free_time[i]) free_time[i] = '0;
  end

  // earliest-free room, lowest number on ties; updates the predictor state
  function automatic booking_t book_interval(logic np, logic [iras_pkg::ID_W-1:0] id,
                                             logic [iras_pkg::TIME_W-1:0] s,
                                             logic [iras_pkg::TIME_W-1:0] e);
    booking_t r;
    int       n;
    int       best;
    if (np) begin
      foreach (free_time[i]) free_time[i] = '0;
      pass_dead = 1'b0;
    end
    r.id = id;
    r.room = '0;
    r.ok = 1'b0;
    if (!pass_dead) begin
      n = room_count_reg;
      if (n < 1) n = 1;
      if (n > MAX_ROOMS) n = MAX_ROOMS;
      best = 0;
      for (int i = 1; i < n; i++) begin
        if (free_time[i] < free_time[best]) best = i;
      end
      if (s >= free_time[best]) begin
        free_time[best] = e;
        r.room = iras_pkg::ROOM_W'(best + 1);
        r.ok = 1'b1;
      end else begin
        pass_dead = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    booking_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (bookings_q.size() == 0) begin
          $error("result beat with nothing expected: out_lecture_echo %0h", out_lecture_echo);
          mismatches++;
        end else begin
          want = bookings_q.pop_front();
          if (out_lecture_echo !== want.id) begin
            $error("out_lecture_echo mismatch: expected %0h, actual %0h",
                   want.id, out_lecture_echo);
            mismatches++;
          end
          if (out_room !== want.room) begin
            $error("out_room mismatch: expected %0d, actual %0d", want.room, out_room);
            mismatches++;
          end
          if (out_ok !== want.ok) begin
            $error("out_ok mismatch: expected %0b, actual %0b", want.ok, out_ok);
            mismatches++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == ROOM_COUNT_ADDR)
        room_count_reg <= pwdata[iras_pkg::ROOM_W-1:0];
      if (start && !busy) begin
        want = book_interval(in_new_pass, in_lecture_id, in_start_time, in_end_time);
        if (fixed_exp) begin
          want.room = fixed_room;
          want.ok = fixed_ok;
        end
        bookings_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one beat, then either stay in the burst or open a gap
  task automatic send_item(input logic np, input logic [iras_pkg::ID_W-1:0] id,
                           input logic [iras_pkg::TIME_W-1:0] s,
                           input logic [iras_pkg::TIME_W-1:0] e,
                           input logic fx, input logic [iras_pkg::ROOM_W-1:0] froom,
                           input logic fok);
    start <= 1'b1;
    in_new_pass <= np;
    in_lecture_id <= id;
    in_start_time <= s;
    in_end_time <= e;
    fixed_exp <= fx;
    fixed_room <= froom;
    fixed_ok <= fok;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // nothing in flight, then room for the longest item to drain
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (bookings_q.size() != 0 || busy);
    repeat (MAX_ROOMS + 4) @(posedge clk);
  endtask

  task automatic write_room_count(input logic [iras_pkg::ROOM_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ROOM_COUNT_ADDR;
    pwdata <= {(iras_pkg::CFG_DW - iras_pkg::ROOM_W)'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned                 random_items;
    int unsigned                 len;
    int unsigned                 step_max;
    int unsigned                 rooms_eff;
    logic [31:0]                 t;
    logic [31:0]                 e;
    logic [iras_pkg::ROOM_W-1:0] rc;
    logic                        carry_on;
    random_items = 0;
    t = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        wait_idle();
        write_room_count(plan[r].cfg_val);
      end else begin
        send_item(plan[r].new_pass, plan[r].id, plan[r].start_t, plan[r].end_t,
                  plan[r].fixed, plan[r].room, plan[r].ok);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: rc = 7'd1;
        1: rc = 7'd64;
        2: rc = 7'd0;
        3: rc = iras_pkg::ROOM_W'($urandom_range(65, 127));
        4: rc = iras_pkg::ROOM_W'($urandom_range(9, 63));
        default: rc = iras_pkg::ROOM_W'($urandom_range(1, 8));
      endcase
      wait_idle();
      write_room_count(rc);
      rooms_eff = (rc == 0) ? 1 : ((rc > MAX_ROOMS) ? MAX_ROOMS : rc);
      // some phases keep the pass running across the room count change
      carry_on = ($urandom_range(0, 3) == 0);
      len = $urandom_range(8, 32);
      step_max = $urandom_range(1, 1000);
      if (!carry_on)
        t = ($urandom_range(0, 4) == 0) ? $urandom_range(32'h4000_0000, 32'h7F00_0000)
                                        : $urandom_range(0, 1000);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(1'($urandom), iras_pkg::ID_W'($urandom),
                    iras_pkg::TIME_W'($urandom), iras_pkg::TIME_W'($urandom),
                    1'b0, '0, 1'b0);
        end else begin
          if ($urandom_range(0, 19) == 0)
            e = t - $urandom_range(1, 50);
          else
            e = t + $urandom_range(0, rooms_eff * step_max);
          send_item(k == 0 && !carry_on, iras_pkg::ID_W'($urandom),
                    iras_pkg::TIME_W'(t), iras_pkg::TIME_W'(e),
                    1'b0, '0, 1'b0);
          t = t + $urandom_range(0, step_max);
        end
      end
      random_items += len;
    end

    wait_idle();
    if (mismatches == 0 && bookings_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/iras_pkg.sv
src/iras_time_store.sv
src/iras_ctrl.sv
src/interval_room_allocator_top.sv
tb/sv/testbench.sv
